/* design/kufa_pkg.sv */
package kufa_pkg;

    localparam int NODES_DEFAULT = 1024;

    localparam int CMD_W    = 2;
    localparam int NODE_W   = 10;
    localparam int WEIGHT_W = 32;
    localparam int COST_W   = 48;
    localparam int COUNT_W  = 11;

    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 64;

    localparam logic [COUNT_W-1:0] NODE_COUNT_RESET = 11'd1024;
    localparam logic [COST_W-1:0]  COST_MAX         = '1;

    localparam logic [CMD_W-1:0] CMD_CLEAR_FOREST = 2'd0;
    localparam logic [CMD_W-1:0] CMD_EDGE         = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR_COST   = 2'd2;

    // Parent table write sources.
    localparam logic [1:0] WR_CLEAR    = 2'd0;
    localparam logic [1:0] WR_COMPRESS = 2'd1;
    localparam logic [1:0] WR_LINK     = 2'd2;

    typedef struct packed {
        logic       capture;
        logic       clear_forest;
        logic       clear_cost;
        logic       merge;
        logic       load_cur;
        logic       cur_from_data;
        logic       start_side;
        logic       root_side;
        logic       set_root;
        logic       wr_en;
        logic [1:0] wr_sel;
        logic       sweep_step;
        logic       out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic [CMD_W-1:0] item_cmd;
        logic             in_range;
        logic             data_is_cur;
        logic             start_a_is_cur;
        logic             start_b_is_cur;
        logic             data_is_root;
        logic             roots_differ;
        logic             sweep_done;
        logic             out_free;
    } dp_status_t;

endpackage

/* design/kufa_dp.sv */
module kufa_dp #(
    parameter int NODES = kufa_pkg::NODES_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [kufa_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    input  logic [kufa_pkg::CMD_W-1:0]       s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [kufa_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    output logic [0:0]                       m_axis_tuser,
    input  logic                             cfg_wr_en,
    input  logic [kufa_pkg::COUNT_W-1:0]     cfg_wr_data,
    input  kufa_pkg::dp_cmd_t                cmd,
    output kufa_pkg::dp_status_t             status
);
    import kufa_pkg::*;

    // Only the first 1024 nodes can be named by an edge.
    localparam int MEM_DEPTH = (NODES < 1024) ? NODES : 1024;
    localparam int MEM_AW    = $clog2(MEM_DEPTH);
    localparam int NODES_CAP = (NODES < 2047) ? NODES : 2047;
    localparam int RESET_ACT = (NODES < 1024) ? NODES : 1024;

    localparam logic [COUNT_W-1:0] DEPTH_V   = COUNT_W'(MEM_DEPTH);
    localparam logic [COUNT_W-1:0] CAP_V     = COUNT_W'(NODES_CAP);
    localparam logic [COUNT_W-1:0] RESET_ACT_V = COUNT_W'(RESET_ACT);

    logic [MEM_AW-1:0] parent_mem [MEM_DEPTH];

    logic [CMD_W-1:0]    cmd_reg;
    logic [NODE_W-1:0]   a_reg;
    logic [NODE_W-1:0]   b_reg;
    logic [WEIGHT_W-1:0] w_reg;

    logic [COUNT_W-1:0] node_count_reg;
    logic [COUNT_W-1:0] active_reg;
    logic [COUNT_W-1:0] comp_reg;
    logic [COST_W-1:0]  cost_reg;
    logic               merged_reg;
    logic [COUNT_W-1:0] sweep_cnt_reg;

    logic [MEM_AW-1:0] cur_reg;
    logic [MEM_AW-1:0] cur_next;
    logic [MEM_AW-1:0] root_a_reg;
    logic [MEM_AW-1:0] root_b_reg;
    logic [MEM_AW-1:0] rd_data_reg;

    logic               out_valid_reg;
    logic               out_merged_reg;
    logic [COST_W-1:0]  out_cost_reg;
    logic [COUNT_W-1:0] out_comp_reg;

    logic [MEM_AW-1:0]  start_a;
    logic [MEM_AW-1:0]  start_b;
    logic [MEM_AW-1:0]  start_sel;
    logic [MEM_AW-1:0]  root_sel;
    logic [COUNT_W-1:0] active_new;
    logic [COST_W:0]    cost_sum;
    logic [MEM_AW-1:0]  wr_addr;
    logic [MEM_AW-1:0]  wr_data;

    assign start_a   = MEM_AW'(a_reg);
    assign start_b   = MEM_AW'(b_reg);
    assign start_sel = cmd.start_side ? start_b : start_a;
    assign root_sel  = cmd.root_side ? root_b_reg : root_a_reg;

    assign active_new = (node_count_reg > CAP_V) ? CAP_V : node_count_reg;
    assign cost_sum   = (COST_W+1)'(cost_reg) + (COST_W+1)'(w_reg);

    always_comb
    begin
        if (cmd.load_cur)
        begin
            cur_next = cmd.cur_from_data ? rd_data_reg : start_sel;
        end
        else
        begin
            cur_next = cur_reg;
        end
    end

    always_comb
    begin
        unique case (cmd.wr_sel)
            WR_CLEAR:
            begin
                wr_addr = sweep_cnt_reg[MEM_AW-1:0];
                wr_data = sweep_cnt_reg[MEM_AW-1:0];
            end
            WR_COMPRESS:
            begin
                wr_addr = cur_reg;
                wr_data = root_sel;
            end
            WR_LINK:
            begin
                wr_addr = root_a_reg;
                wr_data = root_b_reg;
            end
            default:
            begin
                wr_addr = cur_reg;
                wr_data = cur_reg;
            end
        endcase
    end

    // Parent table: one write port, one registered read port that follows cur_next.
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            parent_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= parent_mem[cur_next];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            cmd_reg <= s_axis_tuser;
            a_reg   <= s_axis_tdata[9:0];
            b_reg   <= s_axis_tdata[19:10];
            w_reg   <= s_axis_tdata[51:20];
        end
        cur_reg <= cur_next;
        if (cmd.set_root)
        begin
            if (cmd.root_side)
            begin
                root_b_reg <= cur_reg;
            end
            else
            begin
                root_a_reg <= cur_reg;
            end
        end
        if (cmd.out_load)
        begin
            out_merged_reg <= merged_reg;
            out_cost_reg   <= cost_reg;
            out_comp_reg   <= comp_reg;
        end
        if (cmd.capture)
        begin
            merged_reg <= 1'b0;
        end
        else if (cmd.merge)
        begin
            merged_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= NODE_COUNT_RESET;
            active_reg     <= RESET_ACT_V;
            comp_reg       <= RESET_ACT_V;
            cost_reg       <= '0;
            sweep_cnt_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                node_count_reg <= cfg_wr_data;
            end
            if (cmd.clear_forest)
            begin
                active_reg    <= active_new;
                comp_reg      <= active_new;
                cost_reg      <= '0;
                sweep_cnt_reg <= '0;
            end
            else if (cmd.clear_cost)
            begin
                cost_reg <= '0;
            end
            else if (cmd.merge)
            begin
                cost_reg <= cost_sum[COST_W] ? COST_MAX : cost_sum[COST_W-1:0];
                if (comp_reg != '0)
                begin
                    comp_reg <= comp_reg - COUNT_W'(1);
                end
            end
            if (cmd.sweep_step)
            begin
                sweep_cnt_reg <= sweep_cnt_reg + COUNT_W'(1);
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign status.item_cmd       = cmd_reg;
    assign status.in_range       = (COUNT_W'(a_reg) < active_reg) && (COUNT_W'(b_reg) < active_reg);
    assign status.data_is_cur    = (rd_data_reg == cur_reg);
    assign status.start_a_is_cur = (start_a == cur_reg);
    assign status.start_b_is_cur = (start_b == cur_reg);
    assign status.data_is_root   = (rd_data_reg == root_sel);
    assign status.roots_differ   = (root_a_reg != root_b_reg);
    assign status.sweep_done     = (sweep_cnt_reg >= active_reg) || (sweep_cnt_reg >= DEPTH_V);
    assign status.out_free       = !out_valid_reg || m_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_merged_reg;
    assign m_axis_tdata  = {5'b0, out_comp_reg, out_cost_reg};

endmodule

/* design/kufa_ctrl.sv */
module kufa_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  kufa_pkg::dp_status_t status,
    output kufa_pkg::dp_cmd_t    cmd
);
    import kufa_pkg::*;

    localparam logic [3:0] S_RST_SWEEP = 4'd0;
    localparam logic [3:0] S_IDLE      = 4'd1;
    localparam logic [3:0] S_DECODE    = 4'd2;
    localparam logic [3:0] S_SWEEP     = 4'd3;
    localparam logic [3:0] S_FIND      = 4'd4;
    localparam logic [3:0] S_COMP      = 4'd5;
    localparam logic [3:0] S_LINK      = 4'd6;
    localparam logic [3:0] S_FINISH    = 4'd7;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       side_reg;
    logic       side_next;
    logic       start_is_cur;

    assign start_is_cur = side_reg ? status.start_b_is_cur : status.start_a_is_cur;

    always_comb
    begin
        cmd           = '0;
        state_next    = state_reg;
        side_next     = side_reg;
        s_axis_tready = 1'b0;
        unique case (state_reg) inside
            S_RST_SWEEP, S_SWEEP:
            begin
                if (status.sweep_done)
                begin
                    state_next = (state_reg == S_SWEEP) ? S_FINISH : S_IDLE;
                end
                else
                begin
                    cmd.wr_en      = 1'b1;
                    cmd.wr_sel     = WR_CLEAR;
                    cmd.sweep_step = 1'b1;
                end
            end
            S_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE:
            begin
                unique case (status.item_cmd)
                    CMD_CLEAR_FOREST:
                    begin
                        cmd.clear_forest = 1'b1;
                        state_next       = S_SWEEP;
                    end
                    CMD_CLEAR_COST:
                    begin
                        cmd.clear_cost = 1'b1;
                        state_next     = S_FINISH;
                    end
                    CMD_EDGE:
                    begin
                        if (status.in_range)
                        begin
                            cmd.load_cur = 1'b1;
                            side_next    = 1'b0;
                            state_next   = S_FIND;
                        end
                        else
                        begin
                            state_next = S_FINISH;
                        end
                    end
                    default:
                    begin
                        state_next = S_FINISH;
                    end
                endcase
            end
            S_FIND:
            begin
                cmd.root_side = side_reg;
                if (status.data_is_cur)
                begin
                    cmd.set_root = 1'b1;
                    if (!start_is_cur)
                    begin
                        // Walk the path again from the endpoint and point it at the root.
                        cmd.load_cur   = 1'b1;
                        cmd.start_side = side_reg;
                        state_next     = S_COMP;
                    end
                    else if (!side_reg)
                    begin
                        cmd.load_cur   = 1'b1;
                        cmd.start_side = 1'b1;
                        side_next      = 1'b1;
                    end
                    else
                    begin
                        state_next = S_LINK;
                    end
                end
                else
                begin
                    cmd.load_cur      = 1'b1;
                    cmd.cur_from_data = 1'b1;
                end
            end
            S_COMP:
            begin
                cmd.root_side = side_reg;
                cmd.wr_en     = 1'b1;
                cmd.wr_sel    = WR_COMPRESS;
                if (!status.data_is_root)
                begin
                    cmd.load_cur      = 1'b1;
                    cmd.cur_from_data = 1'b1;
                end
                else if (!side_reg)
                begin
                    cmd.load_cur   = 1'b1;
                    cmd.start_side = 1'b1;
                    side_next      = 1'b1;
                    state_next     = S_FIND;
                end
                else
                begin
                    state_next = S_LINK;
                end
            end
            S_LINK:
            begin
                if (status.roots_differ)
                begin
                    cmd.wr_en  = 1'b1;
                    cmd.wr_sel = WR_LINK;
                    cmd.merge  = 1'b1;
                end
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_RST_SWEEP;
            side_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            side_reg  <= side_next;
        end
    end

endmodule

/* design/kruskal_union_find_accumulator.sv */
// Channel   Direction  tdata (low bit first)                    tuser
// s_axis    in         node_a[9:0], node_b[19:10],               command[1:0]
//                      edge_weight[51:20], zero fill [55:52]
// m_axis    out        total_cost[47:0], component_count[58:48], merged[0]
//                      zero fill [63:59]
// cfg       in         node_count[10:0] on cfg_wr_data when cfg_wr_en is high
//
// One beat is worked on at a time. An edge walks the parent chain from each endpoint;
// every step is one read of the parent table, which has one write port and one
// registered read port. Clear forest sweeps one table entry per node in use (at most
// min(NODES, 1024)). After reset the parent table is swept, min(NODES, 1024) entries,
// with s_axis_tready low. A finished result waits in the output register while the
// next beat is accepted; only its completion stalls on m_axis_tready.
module kruskal_union_find_accumulator #(
    parameter int NODES = kufa_pkg::NODES_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // node_a, node_b, edge_weight
    input  logic [kufa_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // command
    input  logic [kufa_pkg::CMD_W-1:0]       s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // total_cost, component_count
    output logic [kufa_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // merged
    output logic [0:0]                       m_axis_tuser,
    input  logic                             cfg_wr_en,
    input  logic [kufa_pkg::COUNT_W-1:0]     cfg_wr_data
);
    import kufa_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    kufa_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .status        (status),
        .cmd           (cmd)
    );

    kufa_dp #(
        .NODES (NODES)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .cmd           (cmd),
        .status        (status)
    );

endmodule

/* design/kufa_checker.sv */
module kufa_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tready,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [kufa_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input logic [0:0]                       m_axis_tuser
);
    import kufa_pkg::*;

    // A result that is not taken stays put.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser))
        else $error("output beat changed while stalled");

    // The block works on one beat at a time, so it closes the input right after a beat.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted while a beat is in flight");

    // No result can come out of the cycle right after an accept.
    a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))
        else $error("result appeared too early");

    // Padding above the packed output fields stays zero.
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[63:59] == 5'd0)
        else $error("output padding not zero");

endmodule

bind kruskal_union_find_accumulator kufa_checker u_kufa_checker (.*);

/* verif/tb.sv */
`timescale 1ns / 100ps
module tb;
    import kufa_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int NODE_SLOTS  = 1024;
    localparam int MAX_CYCLES  = 2_000_000;
    localparam int IDLE_PCT    = 21;
    localparam int ITEM_TARGET = 1250;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic               merged;
        logic [COST_W-1:0]  cost;
        logic [COUNT_W-1:0] count;
    } tree_status_t;

    class union_find_scoreboard;
        logic [NODE_W-1:0]  parent_tbl [NODE_SLOTS];
        logic [COST_W-1:0]  cost_total;
        logic [COUNT_W-1:0] comp_left;
        logic [COUNT_W-1:0] nodes_live;
        logic [COUNT_W-1:0] node_count_reg;
        tree_status_t       pending [$];
        int                 errors;

        function new();
            errors = 0;
            node_count_reg = NODE_COUNT_RESET;
            clear_forest();
        endfunction

        function void clear_forest();
            for (int i = 0; i < NODE_SLOTS; i++)
            begin
                parent_tbl[i] = NODE_W'(i);
            end
            cost_total = '0;
            nodes_live = (node_count_reg > NODE_SLOTS) ? COUNT_W'(NODE_SLOTS) : node_count_reg;
            comp_left  = nodes_live;
        endfunction

        function void set_node_count(logic [COUNT_W-1:0] value);
            node_count_reg = value;
        endfunction

        // Walks to the root, then points every node on the walk straight at it.
        function logic [NODE_W-1:0] root_of(logic [NODE_W-1:0] node);
            logic [NODE_W-1:0] r;
            logic [NODE_W-1:0] nx;
            int                steps;
            r = node;
            steps = 0;
            while (parent_tbl[r] != r && steps < NODE_SLOTS)
            begin
                r = parent_tbl[r];
                steps++;
            end
            steps = 0;
            while (node != r && steps < NODE_SLOTS)
            begin
                nx = parent_tbl[node];
                parent_tbl[node] = r;
                node = nx;
                steps++;
            end
            return r;
        endfunction

        function void note_item(logic [CMD_W-1:0] cmd, logic [NODE_W-1:0] a,
                                logic [NODE_W-1:0] b, logic [WEIGHT_W-1:0] w);
            tree_status_t      want;
            logic [NODE_W-1:0] ra;
            logic [NODE_W-1:0] rb;
            logic [COST_W:0]   sum;
            want.merged = 1'b0;
            case (cmd)
                CMD_CLEAR_FOREST: clear_forest();
                CMD_CLEAR_COST:   cost_total = '0;
                CMD_EDGE:
                begin
                    if ({1'b0, a} < nodes_live && {1'b0, b} < nodes_live)
                    begin
                        ra = root_of(a);
                        rb = root_of(b);
                        if (ra != rb)
                        begin
                            parent_tbl[ra] = rb;
                            sum = {1'b0, cost_total} + {{(COST_W + 1 - WEIGHT_W){1'b0}}, w};
                            cost_total = sum[COST_W] ? COST_MAX : sum[COST_W-1:0];
                            if (comp_left != 0)
                                comp_left--;
                            want.merged = 1'b1;
                        end
                    end
                end
                default: ;
            endcase
            want.cost  = cost_total;
            want.count = comp_left;
            pending.insert(pending.size(), want);
        endfunction

        function void flag(string what, longint unsigned wanted, longint unsigned got);
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t: %s mismatch: expected %0h, got %0h", $time, what, wanted, got);
        endfunction

        function void check_result(logic merged, logic [COST_W-1:0] cost,
                                   logic [COUNT_W-1:0] count);
            tree_status_t want;
            if (pending.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: result beat with no outstanding item", $time);
                return;
            end
            want = pending.pop_front();
            if (merged !== want.merged)
                flag("merged", want.merged, merged);
            if (cost !== want.cost)
                flag("total_cost", want.cost, cost);
            if (count !== want.count)
                flag("component_count", want.count, count);
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic [CMD_W-1:0]       s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [0:0]             m_axis_tuser;
    logic                   cfg_wr_en;
    logic [COUNT_W-1:0]     cfg_wr_data;

    union_find_scoreboard sb;
    int                   items_sent;
    int                   cycles;
    logic                 calm;

    kruskal_union_find_accumulator DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data)
    );

    initial clk = 1'b0;
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= MAX_CYCLES)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
            m_axis_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tuser[0], m_axis_tdata[COST_W-1:0],
                            m_axis_tdata[COST_W+COUNT_W-1:COST_W]);
    end

    // Entered and left at a falling edge; tvalid stays high after the beat.
    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [NODE_W-1:0] a,
                             input logic [NODE_W-1:0] b, input logic [WEIGHT_W-1:0] w);
        if (!calm)
        begin
            while ($urandom_range(0, 99) < IDLE_PCT)
            begin
                s_axis_tvalid <= 1'b0;
                @(negedge clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_TDATA_W - WEIGHT_W - 2 * NODE_W){1'b0}}, w, b, a};
        s_axis_tuser  <= cmd;
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_item(cmd, a, b, w);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (sb.pending.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_node_count(input logic [COUNT_W-1:0] value);
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        sb.set_node_count(value);
    endtask

    initial
    begin
        logic [COUNT_W-1:0]  count_sel;
        int                  live;
        int                  edges_in_phase;
        int                  pick;
        logic [WEIGHT_W-1:0] weight_floor;
        logic [WEIGHT_W-1:0] w;

        sb = new();
        items_sent    = 0;
        cycles        = 0;
        calm          = 1'b0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = CMD_CLEAR_FOREST;
        m_axis_tready = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = '0;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Full forest straight out of reset.
        send_item(CMD_EDGE, 10'd0, 10'd1023, 32'h0);
        send_item(CMD_EDGE, 10'd1023, 10'd0, '1);
        send_item(CMD_EDGE, 10'h155, 10'h155, 32'h100);
        send_item(CMD_EDGE, 10'h2AA, 10'h155, '1);
        send_item(CMD_EDGE, 10'd1, 10'd0, 32'h8000_0000);
        send_item(CMD_EDGE, 10'd1, 10'd1023, 32'h8000_0000);
        send_item(CMD_UNUSED, '1, '1, '1);
        send_item(CMD_CLEAR_COST, '0, '0, '0);
        send_item(CMD_EDGE, 10'd2, 10'h2AA, 32'h100);

        // A single node: only out-of-range edges and self loops exist.
        write_node_count(COUNT_W'(1));
        send_item(CMD_CLEAR_FOREST, '1, '1, '1);
        send_item(CMD_EDGE, 10'd0, 10'd0, 32'h55);
        send_item(CMD_EDGE, 10'd0, 10'd1, 32'h55);
        send_item(CMD_EDGE, 10'd1, 10'd0, 32'h55);

        // No nodes in use: every edge is dropped.
        write_node_count('0);
        send_item(CMD_CLEAR_FOREST, '0, '0, '0);
        send_item(CMD_EDGE, 10'd0, 10'd0, '1);

        // Counts above the table size clamp to the table size.
        write_node_count('1);
        send_item(CMD_CLEAR_FOREST, '0, '0, '0);
        send_item(CMD_EDGE, 10'd1023, 10'd1022, '1);

        write_node_count(COUNT_W'(2));
        send_item(CMD_CLEAR_FOREST, '0, '0, '0);
        send_item(CMD_EDGE, 10'd0, 10'd1, 32'h5);
        send_item(CMD_EDGE, 10'd1, 10'd0, 32'h7);
        send_item(CMD_EDGE, 10'd0, 10'd2, 32'h9);

        while (items_sent < ITEM_TARGET)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 60)
                count_sel = COUNT_W'($urandom_range(2, 48));
            else if (pick < 75)
                count_sel = COUNT_W'($urandom_range(49, 300));
            else if (pick < 85)
                count_sel = COUNT_W'(NODE_SLOTS);
            else if (pick < 90)
                count_sel = COUNT_W'(1);
            else if (pick < 94)
                count_sel = '0;
            else
                count_sel = COUNT_W'($urandom_range(NODE_SLOTS + 1, 2047));
            write_node_count(count_sel);
            live = (count_sel > NODE_SLOTS) ? NODE_SLOTS : int'(count_sel);
            send_item(CMD_CLEAR_FOREST, NODE_W'($urandom), NODE_W'($urandom), $urandom);
            weight_floor = '0;
            edges_in_phase = $urandom_range(20, 110);
            for (int k = 0; k < edges_in_phase; k++)
            begin
                calm = (items_sent >= 500 && items_sent < 720);
                pick = $urandom_range(0, 99);
                if (pick < 80 && live != 0)
                begin
                    // Mostly sorted by weight, as a spanning-tree host sends them.
                    if ($urandom_range(0, 19) == 0)
                        w = $urandom;
                    else
                    begin
                        if (weight_floor < 32'hFFF0_0000)
                            weight_floor = weight_floor + WEIGHT_W'($urandom_range(0, 50000));
                        w = weight_floor;
                    end
                    send_item(CMD_EDGE, NODE_W'($urandom_range(0, live - 1)),
                              NODE_W'($urandom_range(0, live - 1)), w);
                end
                else if (pick < 88)
                    send_item(CMD_EDGE, NODE_W'($urandom), NODE_W'($urandom), $urandom);
                else if (pick < 93)
                    send_item(CMD_CLEAR_COST, NODE_W'($urandom), NODE_W'($urandom), $urandom);
                else if (pick < 97)
                    send_item(CMD_UNUSED, NODE_W'($urandom), NODE_W'($urandom), $urandom);
                else
                begin
                    send_item(CMD_CLEAR_FOREST, NODE_W'($urandom), NODE_W'($urandom),
                              $urandom);
                    weight_floor = '0;
                end
            end
        end
        calm = 1'b0;

        wait_drained();
        repeat (40) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

/* kruskal_union_find_accumulator.f */
design/kufa_pkg.sv
design/kufa_dp.sv
design/kufa_ctrl.sv
design/kruskal_union_find_accumulator.sv
design/kufa_checker.sv
verif/tb.sv
